// File: rtl/segment_circle_intersection_macros.svh
// ----------------------------------------------------------------------------
// Segment / circle intersection assertion macros
// Shared concurrent assertion forms for the segment / circle datapath.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_CIRCLE_INTERSECTION_MACROS_SVH
`define SEGMENT_CIRCLE_INTERSECTION_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SEGCIRC_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SEGCIRC_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/segcirc_pkg.sv
// ----------------------------------------------------------------------------
// Segment / circle intersection package
// Widths, beat types and lane types shared by the datapath modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package segcirc_pkg;

    localparam int COORD_BITS      = 16;
    localparam int PARAM_FRAC_BITS = 15;
    localparam int RADIUS_BITS     = COORD_BITS - 1;
    localparam int PARAM_BITS      = PARAM_FRAC_BITS + 1;

    localparam int DIFF_BITS = COORD_BITS + 1;
    localparam int PROD_BITS = 2 * DIFF_BITS;
    localparam int VAL_BITS  = 2 * COORD_BITS + 4;
    localparam int WIDE_BITS = 2 * VAL_BITS;
    localparam int DISC_BITS = 4 * COORD_BITS + 4;
    localparam int ROOT_BITS = DISC_BITS / 2 + PARAM_FRAC_BITS;
    localparam int REM_BITS  = ROOT_BITS + 2;
    localparam int NUM_BITS  = VAL_BITS + PARAM_FRAC_BITS + 2;

    localparam logic [PARAM_BITS-1:0] PARAM_ONE = PARAM_BITS'(1) << PARAM_FRAC_BITS;

    typedef struct packed {
        logic signed [COORD_BITS-1:0]  seg_start_x;
        logic signed [COORD_BITS-1:0]  seg_start_y;
        logic signed [COORD_BITS-1:0]  seg_end_x;
        logic signed [COORD_BITS-1:0]  seg_end_y;
        logic signed [COORD_BITS-1:0]  circle_x;
        logic signed [COORD_BITS-1:0]  circle_y;
        logic        [RADIUS_BITS-1:0] circle_radius;
    } seg_query_t;

    typedef struct packed {
        logic                  hit;
        logic [PARAM_BITS-1:0] hit_param;
    } seg_result_t;

    typedef struct packed {
        logic valid;
        logic hit;
        logic use_min;
    } lane_ctl_t;

    typedef struct packed {
        logic        [DISC_BITS-1:0] rad;
        logic        [REM_BITS-1:0]  rem;
        logic        [ROOT_BITS-1:0] root;
        logic signed [VAL_BITS-1:0]  p;
        logic        [VAL_BITS-1:0]  a;
    } sqrt_lane_t;

    typedef struct packed {
        logic [NUM_BITS-1:0]   rem;
        logic [PARAM_BITS-1:0] quo;
        logic [VAL_BITS-1:0]   a;
    } div_lane_t;

endpackage

`default_nettype wire

// File: rtl/segcirc_mul.sv
// ----------------------------------------------------------------------------
// Segment / circle wide multiplier
// Signed product in two stages: four half-width partial products, then sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module segcirc_mul #(
    parameter int WIDTH = segcirc_pkg::VAL_BITS
) (
    input  wire logic                      aclk,
    input  wire logic                      en,
    input  wire logic signed [WIDTH-1:0]   op_a,
    input  wire logic signed [WIDTH-1:0]   op_b,
    output logic signed [2*WIDTH-1:0]      prod
);

    localparam int LO = WIDTH / 2;
    localparam int HI = WIDTH - LO;
    localparam int PW = 2 * WIDTH;

    logic signed [HI-1:0]      a_hi, b_hi;
    logic signed [LO:0]        a_lo, b_lo;
    logic signed [2*HI-1:0]    hh_reg;
    logic signed [HI+LO:0]     hl_reg, lh_reg;
    logic signed [2*LO+1:0]    ll_reg;
    logic signed [PW-1:0]      prod_reg, prod_next;

    assign a_hi = op_a[WIDTH-1:LO];
    assign b_hi = op_b[WIDTH-1:LO];
    assign a_lo = $signed({1'b0, op_a[LO-1:0]});
    assign b_lo = $signed({1'b0, op_b[LO-1:0]});

    always_ff @(posedge aclk) begin
        if (en) begin
            hh_reg <= a_hi * b_hi;
            hl_reg <= a_hi * b_lo;
            lh_reg <= a_lo * b_hi;
            ll_reg <= a_lo * b_lo;
        end
    end

    always_comb begin
        prod_next = (PW'(hh_reg) <<< (2 * LO)) + (PW'(hl_reg) <<< LO)
                  + (PW'(lh_reg) <<< LO) + PW'(ll_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// File: rtl/segcirc_sqrt_cell.sv
// ----------------------------------------------------------------------------
// Segment / circle square root cell
// One digit-by-digit square root step on the discriminant per cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module segcirc_sqrt_cell (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    en,
    input  wire segcirc_pkg::lane_ctl_t  ctl_i,
    input  wire segcirc_pkg::sqrt_lane_t data_i,
    output segcirc_pkg::lane_ctl_t       ctl_o,
    output segcirc_pkg::sqrt_lane_t      data_o
);

    localparam int DB = segcirc_pkg::DISC_BITS;
    localparam int RB = segcirc_pkg::REM_BITS;
    localparam int QB = segcirc_pkg::ROOT_BITS;

    segcirc_pkg::lane_ctl_t  ctl_reg;
    segcirc_pkg::sqrt_lane_t data_reg, data_next;
    logic [RB-1:0] cur, trial;
    logic          ge;

    always_comb begin
        cur   = {data_i.rem[RB-3:0], data_i.rad[DB-1 -: 2]};
        trial = {data_i.root, 2'b01};
        ge    = (cur >= trial);
        data_next      = data_i;
        data_next.rad  = {data_i.rad[DB-3:0], 2'b00};
        data_next.rem  = ge ? (cur - trial) : cur;
        data_next.root = {data_i.root[QB-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= ctl_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign ctl_o  = ctl_reg;
    assign data_o = data_reg;

endmodule

`default_nettype wire

// File: rtl/segcirc_div_cell.sv
// ----------------------------------------------------------------------------
// Segment / circle divider cell
// One restoring division step that decides one bit of the parameter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module segcirc_div_cell #(
    parameter int SHIFT = segcirc_pkg::PARAM_FRAC_BITS
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   en,
    input  wire segcirc_pkg::lane_ctl_t ctl_i,
    input  wire segcirc_pkg::div_lane_t data_i,
    output segcirc_pkg::lane_ctl_t      ctl_o,
    output segcirc_pkg::div_lane_t      data_o
);

    localparam int NB = segcirc_pkg::NUM_BITS;
    localparam int PB = segcirc_pkg::PARAM_BITS;

    segcirc_pkg::lane_ctl_t ctl_reg;
    segcirc_pkg::div_lane_t data_reg, data_next;
    logic [NB-1:0] sub;
    logic          ge;

    always_comb begin
        sub  = NB'(data_i.a) << SHIFT;
        ge   = (data_i.rem >= sub);
        data_next     = data_i;
        data_next.rem = ge ? (data_i.rem - sub) : data_i.rem;
        data_next.quo = data_i.quo | (ge ? (PB'(1) << SHIFT) : '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= ctl_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign ctl_o  = ctl_reg;
    assign data_o = data_reg;

endmodule

`default_nettype wire

// File: rtl/segment_circle_intersection.sv
// ----------------------------------------------------------------------------
// Segment / circle intersection
// Exact first crossing of a segment with a circle, reported as Q1.15.
// ----------------------------------------------------------------------------
// Usage:
// A query beat on s_data (segment start and end, circle center and radius,
// Q8.8) is taken when s_valid and s_ready are both high. One result beat per
// query leaves on m_data with m_valid/m_ready, in query order: hit and the
// segment parameter of the first crossing, truncated, zero on a miss.
// One query is taken every cycle while s_ready is high. The pipeline holds
// the square root row (one cell per root bit, 49 cells) and the divider row
// (one cell per parameter bit, 16 cells).
// When the receiver stalls, the pipeline keeps moving until a finished result
// waits in the output register and a second one in the skid register; then
// s_ready drops until the receiver takes a beat.
// Synchronous active-low reset empties the pipeline and both output registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "segment_circle_intersection_macros.svh"

module segment_circle_intersection (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire segcirc_pkg::seg_query_t s_data,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output segcirc_pkg::seg_result_t     m_data
);

    localparam int FRAC_BITS = segcirc_pkg::PARAM_FRAC_BITS;
    localparam int MUL_WIDTH = segcirc_pkg::VAL_BITS;

    localparam int DB  = segcirc_pkg::DIFF_BITS;
    localparam int PRB = segcirc_pkg::PROD_BITS;
    localparam int VB  = MUL_WIDTH;
    localparam int WB  = segcirc_pkg::WIDE_BITS;
    localparam int RB  = segcirc_pkg::RADIUS_BITS;
    localparam int DSB = segcirc_pkg::DISC_BITS;
    localparam int QB  = segcirc_pkg::ROOT_BITS;
    localparam int NB  = segcirc_pkg::NUM_BITS;
    localparam int PB  = segcirc_pkg::PARAM_BITS;

    logic run;

    logic                 v1_reg;
    logic signed [DB-1:0] dxx_reg, dxy_reg, dyx_reg, dyy_reg;
    logic [RB-1:0]        radius_reg;

    logic                  v2_reg;
    logic signed [PRB-1:0] yxx_reg, yyy_reg, xy1_reg, xy2_reg, xxx_reg, xyy_reg;
    logic [2*RB-1:0]       rsq_reg;

    logic                 v3_reg;
    logic signed [VB-1:0] a3_reg, h3_reg, c3_reg, am3_reg;

    logic signed [WB-1:0] hh_w, ac_w, amsq_w;
    logic                 v4_reg, v5_reg;
    logic signed [VB-1:0] a4_reg, h4_reg, am4_reg, a5_reg, h5_reg, am5_reg;

    logic                 v6_reg;
    logic signed [WB-1:0] d6_reg, hh6_reg, amsq6_reg;
    logic signed [VB-1:0] a6_reg, h6_reg, am6_reg;

    logic                    p_nonneg, le_p, ge_p, le_am, ge_am, am_nonneg;
    logic                    use_min, use_max;
    segcirc_pkg::lane_ctl_t  sel_ctl_reg, sel_ctl_next;
    segcirc_pkg::sqrt_lane_t sel_data_reg, sel_data_next;

    segcirc_pkg::lane_ctl_t  sq_ctl  [0:QB];
    segcirc_pkg::sqrt_lane_t sq_data [0:QB];

    logic signed [NB-1:0]   pk;
    segcirc_pkg::lane_ctl_t num_ctl_reg;
    segcirc_pkg::div_lane_t num_data_reg, num_data_next;

    segcirc_pkg::lane_ctl_t dv_ctl  [0:PB];
    segcirc_pkg::div_lane_t dv_data [0:PB];

    logic                     pv;
    segcirc_pkg::seg_result_t pdata;
    logic                     m_valid_reg, skid_valid_reg;
    segcirc_pkg::seg_result_t m_data_reg, skid_data_reg;

    assign run     = !skid_valid_reg;
    assign s_ready = run;

    // Differences from the query.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (run) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (run) begin
            dxx_reg    <= DB'(s_data.seg_start_x) - DB'(s_data.circle_x);
            dxy_reg    <= DB'(s_data.seg_start_y) - DB'(s_data.circle_y);
            dyx_reg    <= DB'(s_data.seg_end_x) - DB'(s_data.seg_start_x);
            dyy_reg    <= DB'(s_data.seg_end_y) - DB'(s_data.seg_start_y);
            radius_reg <= s_data.circle_radius;
        end
    end

    // Products of the differences.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (run) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (run) begin
            yxx_reg <= dyx_reg * dyx_reg;
            yyy_reg <= dyy_reg * dyy_reg;
            xy1_reg <= dxx_reg * dyx_reg;
            xy2_reg <= dxy_reg * dyy_reg;
            xxx_reg <= dxx_reg * dxx_reg;
            xyy_reg <= dxy_reg * dxy_reg;
            rsq_reg <= radius_reg * radius_reg;
        end
    end

    // Quadratic coefficients a, h = b/2, c and a + h.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (run) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (run) begin
            a3_reg  <= VB'(yxx_reg) + VB'(yyy_reg);
            h3_reg  <= VB'(xy1_reg) + VB'(xy2_reg);
            c3_reg  <= VB'(xxx_reg) + VB'(xyy_reg) - $signed(VB'(rsq_reg));
            am3_reg <= VB'(yxx_reg) + VB'(yyy_reg) + VB'(xy1_reg) + VB'(xy2_reg);
        end
    end

    segcirc_mul #(.WIDTH(VB)) u_mul_hh (
        .aclk(aclk), .en(run), .op_a(h3_reg), .op_b(h3_reg), .prod(hh_w)
    );

    segcirc_mul #(.WIDTH(VB)) u_mul_ac (
        .aclk(aclk), .en(run), .op_a(a3_reg), .op_b(c3_reg), .prod(ac_w)
    );

    segcirc_mul #(.WIDTH(VB)) u_mul_am (
        .aclk(aclk), .en(run), .op_a(am3_reg), .op_b(am3_reg), .prod(amsq_w)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (run) begin
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (run) begin
            a4_reg  <= a3_reg;
            h4_reg  <= h3_reg;
            am4_reg <= am3_reg;
            a5_reg  <= a4_reg;
            h5_reg  <= h4_reg;
            am5_reg <= am4_reg;
        end
    end

    // Discriminant divided by four.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
        end else if (run) begin
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (run) begin
            d6_reg    <= hh_w - ac_w;
            hh6_reg   <= hh_w;
            amsq6_reg <= amsq_w;
            a6_reg    <= a5_reg;
            h6_reg    <= h5_reg;
            am6_reg   <= am5_reg;
        end
    end

    // Root choice. The smaller root is in range when -h >= 0, D <= h*h and
    // a + h is nonnegative or D >= (a + h)^2; the larger one by the mirror test.
    always_comb begin
        p_nonneg  = h6_reg[VB-1] || (h6_reg == '0);
        am_nonneg = !am6_reg[VB-1];
        le_p      = (d6_reg <= hh6_reg);
        ge_p      = (d6_reg >= hh6_reg);
        le_am     = (d6_reg <= amsq6_reg);
        ge_am     = (d6_reg >= amsq6_reg);
        use_min   = p_nonneg && le_p && (am_nonneg || ge_am);
        use_max   = !use_min && (p_nonneg || ge_p) && am_nonneg && le_am;

        sel_ctl_next.valid   = v6_reg;
        sel_ctl_next.hit     = (a6_reg != '0) && !d6_reg[WB-1] && (use_min || use_max);
        sel_ctl_next.use_min = use_min;

        sel_data_next.rad  = d6_reg[DSB-1:0];
        sel_data_next.rem  = '0;
        sel_data_next.root = '0;
        sel_data_next.p    = -h6_reg;
        sel_data_next.a    = a6_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_ctl_reg <= '0;
        end else if (run) begin
            sel_ctl_reg <= sel_ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (run) begin
            sel_data_reg <= sel_data_next;
        end
    end

    assign sq_ctl[0]  = sel_ctl_reg;
    assign sq_data[0] = sel_data_reg;

    for (genvar i = 0; i < QB; i++) begin : g_sqrt
        segcirc_sqrt_cell u_cell (
            .aclk   (aclk),
            .aresetn(aresetn),
            .en     (run),
            .ctl_i  (sq_ctl[i]),
            .data_i (sq_data[i]),
            .ctl_o  (sq_ctl[i+1]),
            .data_o (sq_data[i+1])
        );
    end

    // Numerator of the chosen root, scaled by 2^FRAC_BITS, with the square
    // root rounded up for the smaller root and down for the larger one.
    always_comb begin
        pk = NB'(sq_data[QB].p) <<< FRAC_BITS;
        num_data_next.a   = sq_data[QB].a;
        num_data_next.quo = '0;
        if (sq_ctl[QB].use_min) begin
            num_data_next.rem = NB'(pk - $signed(NB'(sq_data[QB].root))
                                    - $signed(NB'(|sq_data[QB].rem)));
        end else begin
            num_data_next.rem = NB'(pk + $signed(NB'(sq_data[QB].root)));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_ctl_reg <= '0;
        end else if (run) begin
            num_ctl_reg <= sq_ctl[QB];
        end
    end

    always_ff @(posedge aclk) begin
        if (run) begin
            num_data_reg <= num_data_next;
        end
    end

    assign dv_ctl[0]  = num_ctl_reg;
    assign dv_data[0] = num_data_reg;

    for (genvar i = 0; i < PB; i++) begin : g_div
        segcirc_div_cell #(.SHIFT(FRAC_BITS - i)) u_cell (
            .aclk   (aclk),
            .aresetn(aresetn),
            .en     (run),
            .ctl_i  (dv_ctl[i]),
            .data_i (dv_data[i]),
            .ctl_o  (dv_ctl[i+1]),
            .data_o (dv_data[i+1])
        );
    end

    assign pv              = dv_ctl[PB].valid;
    assign pdata.hit       = dv_ctl[PB].hit;
    assign pdata.hit_param = dv_ctl[PB].hit ? dv_data[PB].quo : '0;

    // Output register with a skid register behind it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_valid_reg && !m_ready) begin
            if (pv && run) begin
                skid_valid_reg <= 1'b1;
            end
        end else if (skid_valid_reg) begin
            m_valid_reg    <= 1'b1;
            skid_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= pv;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_valid_reg && !m_ready) begin
            if (run) begin
                skid_data_reg <= pdata;
            end
        end else if (skid_valid_reg) begin
            m_data_reg <= skid_data_reg;
        end else begin
            m_data_reg <= pdata;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `SEGCIRC_ASSERT_IMP(a_skid_behind_out, aclk, aresetn, skid_valid_reg, m_valid_reg, "skid beat without output beat")
    `SEGCIRC_ASSERT_IMP(a_skid_stalls_in, aclk, aresetn, skid_valid_reg, !s_ready, "input open with full skid")
    `SEGCIRC_ASSERT_IMP(a_miss_zero, aclk, aresetn, m_valid_reg && !m_data_reg.hit, m_data_reg.hit_param == '0, "miss with nonzero parameter")
    `SEGCIRC_ASSERT_IMP(a_param_range, aclk, aresetn, m_valid_reg, m_data_reg.hit_param <= segcirc_pkg::PARAM_ONE, "parameter above one")
    `SEGCIRC_ASSERT_NXT(a_skid_fill, aclk, aresetn, m_valid_reg && !m_ready && !skid_valid_reg && pv, skid_valid_reg, "stalled result beat dropped")

endmodule

`default_nettype wire
